FILE: hdl/mwcr_pkg.sv
// Shared types, widths, register indexes and reset values of the mecanum wheel command ramp.
package mwcr_pkg;

	// Field widths.
	localparam int VEL_W      = 16;
	localparam int GEOM_W     = 16;
	localparam int RADIUS_W   = 16;
	localparam int LIMIT_W    = 16;
	localparam int STEP_W     = 15;
	localparam int CNT_W      = 16;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Datapath widths of the shared multiplier.
	localparam int TERM_W  = 21;
	localparam int SUM_W   = 23;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = SUM_W + MUL_B_W;
	localparam int VAL_W   = PROD_W - 8;

	// Fraction shifts.
	localparam int GEOM_FRAC   = 12;
	localparam int RADIUS_FRAC = 8;

	localparam int SPEED_WIDTH_DEF = 16;

	// Operation codes.
	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY_SUM   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_TICKS     = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [GEOM_W-1:0]          RST_GEOMETRY_SUM   = 16'd1229;
	localparam logic [RADIUS_W-1:0]        RST_INVERSE_RADIUS = 16'd5120;
	localparam logic signed [LIMIT_W-1:0]  RST_SPEED_FLOOR    = -16'sd2560;
	localparam logic signed [LIMIT_W-1:0]  RST_SPEED_CEILING  = 16'sd2560;
	localparam logic [STEP_W-1:0]          RST_RAMP_STEP      = 15'd128;
	localparam logic [CNT_W-1:0]           RST_TIMEOUT_TICKS  = 16'd200;
	localparam logic [CNT_W-1:0]           RST_RAMP_TICKS     = 16'd50;

	// Limits handed to the wheel update unit.
	typedef struct packed {
		logic signed [LIMIT_W-1:0] speed_floor;
		logic signed [LIMIT_W-1:0] speed_ceiling;
		logic [STEP_W-1:0]         ramp_step;
	} wheel_cfg_t;

endpackage

FILE: hdl/mwcr_mul.sv
// Shared signed multiplier with a registered product.
module mwcr_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [mwcr_pkg::SUM_W-1:0]    a,
	input  logic signed [mwcr_pkg::MUL_B_W-1:0]  b,
	output logic signed [mwcr_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

FILE: hdl/mwcr_wheel.sv
// Wheel update unit: scales and clamps a product, or steps one wheel toward zero.
module mwcr_wheel #(
	parameter int SPEED_WIDTH = mwcr_pkg::SPEED_WIDTH_DEF
) (
	input  logic                                 ramp_mode,
	input  logic signed [mwcr_pkg::PROD_W-1:0]   prod,
	input  mwcr_pkg::wheel_cfg_t                 cfg,
	input  logic signed [SPEED_WIDTH-1:0]        wheel_in,
	output logic signed [SPEED_WIDTH-1:0]        wheel_out
);

	localparam int RW = ((SPEED_WIDTH > mwcr_pkg::LIMIT_W) ? SPEED_WIDTH : mwcr_pkg::LIMIT_W) + 1;
	localparam logic signed [32:0] SMAX = 33'((64'sd1 <<< (SPEED_WIDTH - 1)) - 64'sd1);
	localparam logic signed [32:0] SMIN = -SMAX - 33'sd1;

	logic signed [mwcr_pkg::PROD_W-1:0]  shifted;
	logic signed [mwcr_pkg::VAL_W-1:0]   val;
	logic signed [mwcr_pkg::VAL_W-1:0]   lo_ext;
	logic signed [mwcr_pkg::VAL_W-1:0]   hi_ext;
	logic signed [mwcr_pkg::VAL_W-1:0]   clamped;
	logic signed [32:0]                  c33;
	logic signed [32:0]                  sat;
	logic signed [SPEED_WIDTH-1:0]       scaled;
	logic signed [RW-1:0]                vr;
	logic signed [RW-1:0]                stp;
	logic signed [RW-1:0]                ramped;

	// Command path: floor shift, then floor, ceiling and width saturation in that order.
	always_comb begin
		shifted = prod >>> mwcr_pkg::RADIUS_FRAC;
		val     = shifted[mwcr_pkg::VAL_W-1:0];
		lo_ext  = mwcr_pkg::VAL_W'(cfg.speed_floor);
		hi_ext  = mwcr_pkg::VAL_W'(cfg.speed_ceiling);
		clamped = val;
		if (clamped < lo_ext) begin
			clamped = lo_ext;
		end
		if (clamped > hi_ext) begin
			clamped = hi_ext;
		end
		// After the floor and ceiling the value fits the 16-bit limit range.
		c33 = 33'(signed'(clamped[mwcr_pkg::LIMIT_W-1:0]));
		if (c33 > SMAX) begin
			sat = SMAX;
		end else if (c33 < SMIN) begin
			sat = SMIN;
		end else begin
			sat = c33;
		end
		scaled = sat[SPEED_WIDTH-1:0];
	end

	// Ramp path: move toward zero by the step, or land on zero within it.
	always_comb begin
		vr  = RW'(wheel_in);
		stp = RW'(signed'({1'b0, cfg.ramp_step}));
		if (vr > stp) begin
			ramped = vr - stp;
		end else if (vr < -stp) begin
			ramped = vr + stp;
		end else begin
			ramped = '0;
		end
	end

	assign wheel_out = ramp_mode ? ramped[SPEED_WIDTH-1:0] : scaled;

endmodule

FILE: hdl/mecanum_wheel_command_ramp_top.sv
// Top level of the mecanum wheel command ramp: sequencer, state and channel registers.
//
// Input channel (in_valid / in_stall): operation selects a velocity command or a time tick.
// A command computes four wheel speeds with one shared multiplier, five products in
// alternating multiply and write-back cycles, and re-arms the watchdog. A tick counts
// the watchdog down; at expiry the wheels step toward zero one at a time through the
// shared wheel unit, and the watchdog re-arms with the ramp period while any wheel moves.
// One request is worked on at a time and in_stall is high meanwhile.
// A command runs five multiply and write-back pairs and then loads the output register;
// a tick that ramps runs four wheel-unit steps and the load, any other tick only the load.
// Output channel (out_valid / out_stall): one result per request, the wheel speeds held
// after that request and the watchdog state. The result sits in an output register, so
// the next request is accepted while it waits; if the receiver stalls, a finished request
// holds in place until the register frees up.
// Configuration (cfg_valid / cfg_ready) is always ready and is to be written by the user
// only while idle; the block itself does not enforce this. Reset clears the wheels,
// disarms the watchdog and loads the default configuration.
module mecanum_wheel_command_ramp_top #(
	parameter int SPEED_WIDTH = mwcr_pkg::SPEED_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input channel.
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  operation,
	input  logic signed [mwcr_pkg::VEL_W-1:0]     vel_x,
	input  logic signed [mwcr_pkg::VEL_W-1:0]     vel_y,
	input  logic signed [mwcr_pkg::VEL_W-1:0]     turn_rate,
	// Output channel.
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mwcr_pkg::OUT_W-1:0]     speed_fl,
	output logic signed [mwcr_pkg::OUT_W-1:0]     speed_fr,
	output logic signed [mwcr_pkg::OUT_W-1:0]     speed_rl,
	output logic signed [mwcr_pkg::OUT_W-1:0]     speed_rr,
	output logic                                  watchdog_armed,
	// Configuration channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mwcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mwcr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_WB   = 3'd2;
	localparam logic [2:0] S_RAMP = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [2:0] IDX_FL   = 3'd1;
	localparam logic [2:0] IDX_FR   = 3'd2;
	localparam logic [2:0] IDX_RL   = 3'd3;
	localparam logic [2:0] IDX_RR   = 3'd4;
	localparam logic [2:0] IDX_TURN = 3'd0;
	localparam logic [1:0] LAST_WHEEL = 2'd3;

	// Configuration registers.
	logic [mwcr_pkg::GEOM_W-1:0]          geometry_sum_q;
	logic [mwcr_pkg::RADIUS_W-1:0]        inverse_radius_q;
	logic signed [mwcr_pkg::LIMIT_W-1:0]  speed_floor_q;
	logic signed [mwcr_pkg::LIMIT_W-1:0]  speed_ceiling_q;
	logic [mwcr_pkg::STEP_W-1:0]          ramp_step_q;
	logic [mwcr_pkg::CNT_W-1:0]           timeout_ticks_q;
	logic [mwcr_pkg::CNT_W-1:0]           ramp_ticks_q;

	// Block state.
	logic [2:0]                           state_q;
	logic [2:0]                           idx_q;
	logic signed [SPEED_WIDTH-1:0]        wheel_q [4];
	logic [mwcr_pkg::CNT_W-1:0]           countdown_q;
	logic                                 armed_q;
	logic                                 moving_q;

	// Latched operands.
	logic signed [mwcr_pkg::VEL_W-1:0]    vx_q;
	logic signed [mwcr_pkg::VEL_W-1:0]    vy_q;
	logic signed [mwcr_pkg::VEL_W-1:0]    w_q;
	logic signed [mwcr_pkg::TERM_W-1:0]   t_q;

	// Output register.
	logic                                 out_valid_q;
	logic signed [mwcr_pkg::OUT_W-1:0]    out_wheel_q [4];
	logic                                 out_armed_q;

	logic                                 accept;
	logic                                 out_free;
	logic                                 neg_y;
	logic                                 neg_t;
	logic signed [mwcr_pkg::SUM_W-1:0]    sum;
	logic signed [mwcr_pkg::SUM_W-1:0]    mul_a;
	logic signed [mwcr_pkg::MUL_B_W-1:0]  mul_b;
	logic signed [mwcr_pkg::PROD_W-1:0]   prod;
	logic signed [mwcr_pkg::PROD_W-1:0]   turn_shift;
	logic [1:0]                           wr_sel;
	logic signed [SPEED_WIDTH-1:0]        wheel_new;
	mwcr_pkg::wheel_cfg_t                 wheel_cfg;
	logic signed [mwcr_pkg::OUT_W-1:0]    wheel_out16 [4];

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geometry_sum_q   <= mwcr_pkg::RST_GEOMETRY_SUM;
			inverse_radius_q <= mwcr_pkg::RST_INVERSE_RADIUS;
			speed_floor_q    <= mwcr_pkg::RST_SPEED_FLOOR;
			speed_ceiling_q  <= mwcr_pkg::RST_SPEED_CEILING;
			ramp_step_q      <= mwcr_pkg::RST_RAMP_STEP;
			timeout_ticks_q  <= mwcr_pkg::RST_TIMEOUT_TICKS;
			ramp_ticks_q     <= mwcr_pkg::RST_RAMP_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mwcr_pkg::REG_GEOMETRY_SUM:   geometry_sum_q   <= cfg_data;
				mwcr_pkg::REG_INVERSE_RADIUS: inverse_radius_q <= cfg_data;
				mwcr_pkg::REG_SPEED_FLOOR:    speed_floor_q    <= signed'(cfg_data);
				mwcr_pkg::REG_SPEED_CEILING:  speed_ceiling_q  <= signed'(cfg_data);
				mwcr_pkg::REG_RAMP_STEP:      ramp_step_q      <= cfg_data[mwcr_pkg::STEP_W-1:0];
				mwcr_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_q  <= cfg_data;
				mwcr_pkg::REG_RAMP_TICKS:     ramp_ticks_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Wheel sums: FL = vx - vy - t, FR = vx + vy + t, RL = vx + vy - t, RR = vx - vy + t.
	always_comb begin
		neg_y = (idx_q == IDX_FL) || (idx_q == IDX_RR);
		neg_t = (idx_q == IDX_FL) || (idx_q == IDX_RL);
		sum   = mwcr_pkg::SUM_W'(vx_q)
			+ (neg_y ? -mwcr_pkg::SUM_W'(vy_q) : mwcr_pkg::SUM_W'(vy_q))
			+ (neg_t ? -mwcr_pkg::SUM_W'(t_q) : mwcr_pkg::SUM_W'(t_q));
		if (idx_q == IDX_TURN) begin
			mul_a = mwcr_pkg::SUM_W'(w_q);
			mul_b = signed'({1'b0, geometry_sum_q});
		end else begin
			mul_a = sum;
			mul_b = signed'({1'b0, inverse_radius_q});
		end
		turn_shift = prod >>> mwcr_pkg::GEOM_FRAC;
	end

	mwcr_mul u_mul (
		.clk    (clk),
		.en     (state_q == S_MUL),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign wheel_cfg.speed_floor   = speed_floor_q;
	assign wheel_cfg.speed_ceiling = speed_ceiling_q;
	assign wheel_cfg.ramp_step     = ramp_step_q;

	assign wr_sel = (state_q == S_RAMP) ? idx_q[1:0] : 2'(idx_q - 3'd1);

	mwcr_wheel #(
		.SPEED_WIDTH (SPEED_WIDTH)
	) u_wheel (
		.ramp_mode (state_q == S_RAMP),
		.prod      (prod),
		.cfg       (wheel_cfg),
		.wheel_in  (wheel_q[idx_q[1:0]]),
		.wheel_out (wheel_new)
	);

	// Sequencer and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			countdown_q <= '0;
			armed_q     <= 1'b0;
			moving_q    <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				wheel_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						moving_q <= 1'b0;
						if (operation == mwcr_pkg::OP_COMMAND) begin
							state_q <= S_MUL;
						end else if (armed_q && countdown_q <= 16'd1) begin
							state_q <= S_RAMP;
						end else begin
							if (armed_q) begin
								countdown_q <= countdown_q - 16'd1;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (idx_q != IDX_TURN) begin
						wheel_q[wr_sel] <= wheel_new;
					end
					if (idx_q == IDX_RR) begin
						countdown_q <= timeout_ticks_q;
						armed_q     <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				S_RAMP: begin
					wheel_q[wr_sel] <= wheel_new;
					if (idx_q[1:0] == LAST_WHEEL) begin
						// Re-arm with the ramp period only while some wheel still turns.
						if (moving_q || wheel_new != '0) begin
							armed_q     <= 1'b1;
							countdown_q <= ramp_ticks_q;
						end else begin
							armed_q     <= 1'b0;
							countdown_q <= '0;
						end
						state_q <= S_DONE;
					end else begin
						moving_q <= moving_q || (wheel_new != '0);
						idx_q    <= idx_q + 3'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operands are latched on accept; the turn term is stored once its product is ready.
	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= vel_x;
			vy_q <= vel_y;
			w_q  <= turn_rate;
		end
		if (state_q == S_WB && idx_q == IDX_TURN) begin
			t_q <= turn_shift[mwcr_pkg::TERM_W-1:0];
		end
	end

	// Wheel speeds brought to the 16-bit output width by sign extension or truncation.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int b = 0; b < mwcr_pkg::OUT_W; b++) begin
				wheel_out16[i][b] = wheel_q[i][(b < SPEED_WIDTH) ? b : SPEED_WIDTH - 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			for (int i = 0; i < 4; i++) begin
				out_wheel_q[i] <= wheel_out16[i];
			end
			out_armed_q <= armed_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign speed_fl       = out_wheel_q[0];
	assign speed_fr       = out_wheel_q[1];
	assign speed_rl       = out_wheel_q[2];
	assign speed_rr       = out_wheel_q[3];
	assign watchdog_armed = out_armed_q;

`ifndef ASSERT_OFF
	a_disarmed_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> countdown_q == '0)
		else $error("watchdog disarmed with a nonzero countdown");

	a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
		else $error("finished request left while the output register was stalled");

	a_wb_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB || state_q == S_MUL) |-> idx_q <= IDX_RR)
		else $error("command sequencer index out of range");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result shown without a finished request");
`endif

endmodule
